// ===== rtl/lwpl_pkg.sv =====
// Shared types and constants for the light window peak locator.
`timescale 1ns / 1ps
package lwpl_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int LEVEL_W = 12;
	localparam int POS_W = 32;
	localparam int SEP_W = 31;
	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W = 1;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [SEP_W-1:0] sep_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION = 1'd1;

	localparam level_t THRESHOLD_RESET = 12'd2000;
	localparam sep_t SEPARATION_RESET = 31'd151039;
	localparam level_t LEVEL_MAX = 12'd4095;

endpackage

// ===== rtl/lwpl_if.sv =====
// Sample and result channel interfaces of the light window peak locator.
`timescale 1ns / 1ps
interface lwpl_in_if import lwpl_pkg::*; ();
	logic valid;
	logic ready;
	pos_t position;
	level_t light_level;
	logic first_sample;
	logic last_sample;

	modport source (output valid, position, light_level, first_sample, last_sample,
		input ready);
	modport sink (input valid, position, light_level, first_sample, last_sample,
		output ready);
endinterface

interface lwpl_out_if import lwpl_pkg::*; ();
	logic valid;
	logic ready;
	pos_t slot0_position;
	pos_t slot1_position;
	pos_t slot2_position;
	pos_t slot3_position;
	logic [2:0] windows_found;
	logic success;

	modport source (output valid, slot0_position, slot1_position, slot2_position,
		slot3_position, windows_found, success, input ready);
	modport sink (input valid, slot0_position, slot1_position, slot2_position,
		slot3_position, windows_found, success, output ready);
endinterface

// ===== rtl/light_window_peak_locator.sv =====
// Top level of the light window peak locator.
`timescale 1ns / 1ps
// The samples channel takes one scan sample per item: an encoder position, a
// light level, and first/last markers. A sample with first_sample set clears
// the stored windows before it is processed. Each sample is folded into the
// window tracker and the four slots in the cycle it is accepted, so the block
// takes one sample per cycle.
// A sample with last_sample set produces one result item on the results
// channel, valid in the cycle after the sample is accepted. The result sits
// in an output register; while it waits, a new sample is still accepted
// unless it is itself a last sample that would overwrite the waiting result.
// The rate is therefore one sample per cycle, limited only by the result
// register when last samples meet a stalled receiver.
// Configuration writes (threshold, minimum separation) take effect on the
// next sample. Reset restores the register defaults, clears all slots and
// the window state, and empties the result register.
module light_window_peak_locator import lwpl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	lwpl_in_if.sink samples,
	lwpl_out_if.source results
);

	level_t threshold_q;
	sep_t separation_q;

	logic in_window_q;
	level_t win_min_q;
	pos_t win_pos_q;
	cnt_t count_q;
	pos_t slot_pos_q [SLOT_COUNT];
	pos_t last_pos_q;
	level_t last_str_q;

	logic in_window_d;
	level_t win_min_d;
	pos_t win_pos_d;
	cnt_t count_d;
	pos_t slot_pos_d [SLOT_COUNT];
	pos_t last_pos_d;
	level_t last_str_d;

	logic in_window_b;
	level_t win_min_b;
	pos_t win_pos_b;
	cnt_t count_b;
	pos_t slot_pos_b [SLOT_COUNT];
	pos_t last_pos_b;
	level_t last_str_b;

	logic signed [POS_W:0] diff;
	logic [POS_W:0] mag;
	logic near;
	logic accept;

	logic out_valid_q;
	pos_t out_pos_q [4];
	logic [2:0] out_found_q;
	logic out_success_q;

	assign accept = samples.valid && samples.ready;
	assign samples.ready = !out_valid_q || results.ready || !samples.last_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			separation_q <= SEPARATION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[LEVEL_W-1:0];
				CFG_SEPARATION: separation_q <= cfg_data[SEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (samples.first_sample) begin
			in_window_b = 1'b0;
			win_min_b = LEVEL_MAX;
			win_pos_b = '0;
			count_b = '0;
			for (int i = 0; i < SLOT_COUNT; i++) slot_pos_b[i] = '0;
			last_pos_b = '0;
			last_str_b = LEVEL_MAX;
		end else begin
			in_window_b = in_window_q;
			win_min_b = win_min_q;
			win_pos_b = win_pos_q;
			count_b = count_q;
			for (int i = 0; i < SLOT_COUNT; i++) slot_pos_b[i] = slot_pos_q[i];
			last_pos_b = last_pos_q;
			last_str_b = last_str_q;
		end
	end

	assign diff = {win_pos_b[POS_W-1], win_pos_b} - {last_pos_b[POS_W-1], last_pos_b};
	assign mag = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
	assign near = mag < {2'b00, separation_q};

	always_comb begin
		in_window_d = in_window_b;
		win_min_d = win_min_b;
		win_pos_d = win_pos_b;
		count_d = count_b;
		for (int i = 0; i < SLOT_COUNT; i++) slot_pos_d[i] = slot_pos_b[i];
		last_pos_d = last_pos_b;
		last_str_d = last_str_b;
		if (samples.light_level < threshold_q) begin
			if (!in_window_b || samples.light_level < win_min_b) begin
				in_window_d = 1'b1;
				win_min_d = samples.light_level;
				win_pos_d = samples.position;
			end
		end else if (in_window_b) begin
			in_window_d = 1'b0;
			if (count_b < CNT_W'(SLOT_COUNT)) begin
				if (count_b != '0 && near) begin
					if (win_min_b < last_str_b) begin
						for (int i = 0; i < SLOT_COUNT; i++) begin
							if (count_b == CNT_W'(i + 1)) slot_pos_d[i] = win_pos_b;
						end
						last_pos_d = win_pos_b;
						last_str_d = win_min_b;
					end
				end else begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (count_b == CNT_W'(i)) slot_pos_d[i] = win_pos_b;
					end
					last_pos_d = win_pos_b;
					last_str_d = win_min_b;
					count_d = count_b + CNT_W'(1);
				end
			end
		end
		if (samples.last_sample) begin
			in_window_d = 1'b0;
			win_min_d = LEVEL_MAX;
			win_pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_window_q <= 1'b0;
			win_min_q <= LEVEL_MAX;
			win_pos_q <= '0;
			count_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) slot_pos_q[i] <= '0;
			last_pos_q <= '0;
			last_str_q <= LEVEL_MAX;
		end else if (accept) begin
			in_window_q <= in_window_d;
			win_min_q <= win_min_d;
			win_pos_q <= win_pos_d;
			count_q <= count_d;
			for (int i = 0; i < SLOT_COUNT; i++) slot_pos_q[i] <= slot_pos_d[i];
			last_pos_q <= last_pos_d;
			last_str_q <= last_str_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && samples.last_sample) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && samples.last_sample) begin
			for (int j = 0; j < 4; j++) begin
				out_pos_q[j] <= (j < SLOT_COUNT) ? slot_pos_d[j] : '0;
			end
			out_found_q <= (count_d > CNT_W'(7)) ? 3'd7 : 3'(count_d);
			out_success_q <= (count_d == CNT_W'(SLOT_COUNT));
		end
	end

	assign results.valid = out_valid_q;
	assign results.slot0_position = out_pos_q[0];
	assign results.slot1_position = out_pos_q[1];
	assign results.slot2_position = out_pos_q[2];
	assign results.slot3_position = out_pos_q[3];
	assign results.windows_found = out_found_q;
	assign results.success = out_success_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOT_COUNT))
		else $error("slot count exceeds the number of slots");

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.last_sample) |=> results.valid)
		else $error("last sample did not produce a result item");

	a_success_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.success == (results.windows_found == 3'(SLOT_COUNT))))
		else $error("success flag disagrees with windows found");

	a_no_window_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.last_sample) |=> !in_window_q)
		else $error("window state survived the end of a scan");

endmodule
